// ----- sv/quadratic_root_solver_core_macros.svh -----
// ----------------------------------------------------------------------------
// quadratic root solver assertion macros
// concurrent checks clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// same-cycle implication
`define QRS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication
`define QRS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ----- sv/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// widths, codes and types shared by the quadratic root solver
// ----------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;
   localparam int FRAC_BITS = 16;
   localparam int COEF_W    = 16;
   localparam int ROOT_W    = 34;
   localparam int DISC_W    = 2 * COEF_W + 2;
   localparam int RAD_W     = DISC_W - 1 + 2 * FRAC_BITS;
   localparam int RT_W      = (RAD_W + 1) / 2;
   localparam int RAD2_W    = 2 * RT_W;
   localparam int REM_W     = RT_W + 3;
   localparam int SUM_W     = RT_W + 3;
   localparam int NUM_W     = SUM_W - 1;
   localparam int DVS_W     = COEF_W + 1;
   localparam int VAL_W     = (NUM_W + 1 > ROOT_W) ? NUM_W + 1 : ROOT_W;

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_ONE  = 2'd1,
      ST_TWO  = 2'd2,
      ST_NOTQ = 2'd3
   } status_type;

   typedef struct packed {
      status_type         status;
      logic               qneg;
      logic signed [COEF_W:0] p;
      logic [DVS_W-1:0]   dvs;
   } side_type;
endpackage
`default_nettype wire

// ----- sv/qrs_req_if.sv -----
// ----------------------------------------------------------------------------
// qrs_req_if
// request channel: coefficients of one quadratic
// ----------------------------------------------------------------------------
`default_nettype none
interface qrs_req_if;
   import qrs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coef_quad;
   logic signed [COEF_W-1:0] coef_lin;
   logic signed [COEF_W-1:0] coef_const;
   modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
   modport sink (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface
`default_nettype wire

// ----- sv/qrs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// qrs_rsp_if
// response channel: status and roots of one quadratic
// ----------------------------------------------------------------------------
`default_nettype none
interface qrs_rsp_if;
   import qrs_pkg::*;
   logic                     valid;
   logic                     ready;
   status_type               root_status;
   logic signed [ROOT_W-1:0] root_plus;
   logic signed [ROOT_W-1:0] root_minus;
   modport source (output valid, root_status, root_plus, root_minus, input ready);
   modport sink (input valid, root_status, root_plus, root_minus, output ready);
endinterface
`default_nettype wire

// ----- sv/qrs_disc.sv -----
// ----------------------------------------------------------------------------
// qrs_disc
// two stages: products, then discriminant, status and divisor setup
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_disc (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] in_a,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] in_b,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] in_c,
   output logic                                  out_valid,
   output qrs_pkg::side_type                     out_side,
   output logic [qrs_pkg::DISC_W-2:0]            out_disc
);
   import qrs_pkg::*;

   logic                       v1_ff;
   logic signed [COEF_W-1:0]   a_ff, b_ff;
   logic signed [2*COEF_W-1:0] bb_ff, ac_ff;
   logic signed [2*COEF_W-1:0] bb_in, ac_in;
   logic signed [DISC_W-1:0]   disc;
   logic signed [COEF_W:0]     a2, bx;
   side_type                   side_in, side_ff;
   logic [DISC_W-2:0]          disc_in, disc_ff;
   logic                       v2_ff;

   assign bb_in = in_b * in_b;
   assign ac_in = in_a * in_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         a_ff    <= in_a;
         b_ff    <= in_b;
         bb_ff   <= bb_in;
         ac_ff   <= ac_in;
         side_ff <= side_in;
         disc_ff <= disc_in;
      end
   end

   always_comb begin
      disc = {{2{bb_ff[2*COEF_W-1]}}, bb_ff} - {ac_ff, 2'b00};
      a2   = {a_ff, 1'b0};
      bx   = {b_ff[COEF_W-1], b_ff};
      side_in.qneg = a_ff[COEF_W-1];
      side_in.p    = a_ff[COEF_W-1] ? bx : -bx;
      side_in.dvs  = a_ff[COEF_W-1] ? DVS_W'(-a2) : DVS_W'(a2);
      if (a_ff == '0)
         side_in.status = ST_NOTQ;
      else if (disc[DISC_W-1])
         side_in.status = ST_NONE;
      else if (disc == '0)
         side_in.status = ST_ONE;
      else
         side_in.status = ST_TWO;
      disc_in = disc[DISC_W-1] ? '0 : disc[DISC_W-2:0];
   end

   assign out_valid = v2_ff;
   assign out_side  = side_ff;
   assign out_disc  = disc_ff;
endmodule
`default_nettype wire

// ----- sv/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined digit-by-digit square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire qrs_pkg::side_type          in_side,
   input  wire logic [qrs_pkg::DISC_W-2:0] in_disc,
   output logic                            out_valid,
   output qrs_pkg::side_type               out_side,
   output logic [qrs_pkg::RT_W-1:0]        out_root,
   output logic                            out_exact
);
   import qrs_pkg::*;

   logic [REM_W-1:0]  rem_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic [RAD2_W-1:0] rad_ff  [RT_W];
   side_type          side_ff [RT_W];
   logic [RT_W-1:0]   valid_ff;

   logic [REM_W-1:0]  rem_cur  [RT_W];
   logic [REM_W-1:0]  rem_sh   [RT_W];
   logic [REM_W-1:0]  trial    [RT_W];
   logic [RT_W-1:0]   root_cur [RT_W];
   logic [RAD2_W-1:0] rad_cur  [RT_W];
   side_type          side_cur [RT_W];
   logic [RT_W-1:0]   valid_cur;
   logic [RT_W-1:0]   ge;

   always_comb begin
      for (int k = 0; k < RT_W; k++) begin
         if (k == 0) begin
            rem_cur[k]   = '0;
            root_cur[k]  = '0;
            rad_cur[k]   = RAD2_W'({in_disc, {(2*FRAC_BITS){1'b0}}});
            side_cur[k]  = in_side;
            valid_cur[k] = in_valid;
         end else begin
            rem_cur[k]   = rem_ff[k-1];
            root_cur[k]  = root_ff[k-1];
            rad_cur[k]   = rad_ff[k-1];
            side_cur[k]  = side_ff[k-1];
            valid_cur[k] = valid_ff[k-1];
         end
         rem_sh[k] = {rem_cur[k][REM_W-3:0], rad_cur[k][RAD2_W-1 -: 2]};
         trial[k]  = REM_W'({root_cur[k], 2'b01});
         ge[k]     = rem_sh[k] >= trial[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (en)
         valid_ff <= valid_cur;
      if (en) begin
         for (int k = 0; k < RT_W; k++) begin
            rem_ff[k]  <= ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
            root_ff[k] <= {root_cur[k][RT_W-2:0], ge[k]};
            rad_ff[k]  <= rad_cur[k] << 2;
            side_ff[k] <= side_cur[k];
         end
      end
   end

   assign out_valid = valid_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_exact = rem_ff[RT_W-1] == '0;
endmodule
`default_nettype wire

// ----- sv/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// numerator setup, two-lane pipelined restoring divider, rounding and clamp
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire qrs_pkg::side_type         in_side,
   input  wire logic [qrs_pkg::RT_W-1:0]  in_root,
   input  wire logic                      in_exact,
   output logic                           out_valid,
   output qrs_pkg::status_type            out_status,
   output logic signed [qrs_pkg::ROOT_W-1:0] out_plus,
   output logic signed [qrs_pkg::ROOT_W-1:0] out_minus
);
   import qrs_pkg::*;

   logic signed [SUM_W-1:0] base, rtx, incx;
   logic signed [SUM_W-1:0] add_f, add_c, sub_f, sub_c;
   logic signed [SUM_W-1:0] fl [2];
   logic signed [SUM_W-1:0] cl [2];
   logic signed [SUM_W-1:0] mag [2];
   logic [NUM_W-1:0]        pnq_in [2];
   logic [1:0]              pneg_in;

   logic [NUM_W-1:0] pnq_ff [2];
   logic [1:0]       pneg_ff;
   side_type         pside_ff;
   logic             pvalid_ff;

   logic [DVS_W-1:0] rem_ff  [NUM_W][2];
   logic [NUM_W-1:0] nq_ff   [NUM_W][2];
   logic [1:0]       neg_ff  [NUM_W];
   side_type         side_ff [NUM_W];
   logic [NUM_W-1:0] valid_ff;

   logic [DVS_W-1:0] rem_cur [NUM_W][2];
   logic [NUM_W-1:0] nq_cur  [NUM_W][2];
   logic [DVS_W:0]   rem_sh  [NUM_W][2];
   logic [1:0]       neg_cur [NUM_W];
   side_type         side_cur [NUM_W];
   logic [NUM_W-1:0] valid_cur;
   logic             ge      [NUM_W][2];

   logic signed [VAL_W-1:0]  vext [2];
   logic signed [ROOT_W-1:0] vsat [2];
   logic                     ovf  [2];
   logic signed [ROOT_W-1:0] plus_ff, minus_ff;
   status_type               status_ff;
   logic                     ovalid_ff;

   // numerator for each lane, sign folded into a magnitude
   always_comb begin
      base  = {{(SUM_W-COEF_W-1){in_side.p[COEF_W]}}, in_side.p} <<< FRAC_BITS;
      rtx   = SUM_W'(in_root);
      incx  = SUM_W'(!in_exact);
      add_f = base + rtx;
      add_c = add_f + incx;
      sub_c = base - rtx;
      sub_f = sub_c - incx;
      for (int l = 0; l < 2; l++) begin
         if ((l == 0) != in_side.qneg) begin
            fl[l] = add_f;
            cl[l] = add_c;
         end else begin
            fl[l] = sub_f;
            cl[l] = sub_c;
         end
         pneg_in[l] = fl[l][SUM_W-1];
         mag[l]     = pneg_in[l] ? -cl[l] : fl[l];
         pnq_in[l]  = mag[l][NUM_W-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            neg_cur[k]   = pneg_ff;
            side_cur[k]  = pside_ff;
            valid_cur[k] = pvalid_ff;
         end else begin
            neg_cur[k]   = neg_ff[k-1];
            side_cur[k]  = side_ff[k-1];
            valid_cur[k] = valid_ff[k-1];
         end
         for (int l = 0; l < 2; l++) begin
            if (k == 0) begin
               rem_cur[k][l] = '0;
               nq_cur[k][l]  = pnq_ff[l];
            end else begin
               rem_cur[k][l] = rem_ff[k-1][l];
               nq_cur[k][l]  = nq_ff[k-1][l];
            end
            rem_sh[k][l] = {rem_cur[k][l], nq_cur[k][l][NUM_W-1]};
            ge[k][l]     = rem_sh[k][l] >= {1'b0, side_cur[k].dvs};
         end
      end
   end

   // final rounding toward zero is already in the magnitude; apply sign and clamp
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         vext[l] = neg_ff[NUM_W-1][l] ? -VAL_W'(nq_ff[NUM_W-1][l])
                                      : VAL_W'(nq_ff[NUM_W-1][l]);
         ovf[l]  = !((vext[l][VAL_W-1:ROOT_W-1] == '0) ||
                     (vext[l][VAL_W-1:ROOT_W-1] == '1));
         if (ovf[l])
            vsat[l] = neg_ff[NUM_W-1][l] ? {1'b1, {(ROOT_W-1){1'b0}}}
                                         : {1'b0, {(ROOT_W-1){1'b1}}};
         else
            vsat[l] = vext[l][ROOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         valid_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else if (en) begin
         pvalid_ff <= in_valid;
         valid_ff  <= valid_cur;
         ovalid_ff <= valid_ff[NUM_W-1];
      end
      if (en) begin
         pnq_ff   <= pnq_in;
         pneg_ff  <= pneg_in;
         pside_ff <= in_side;
         for (int k = 0; k < NUM_W; k++) begin
            neg_ff[k]  <= neg_cur[k];
            side_ff[k] <= side_cur[k];
            for (int l = 0; l < 2; l++) begin
               rem_ff[k][l] <= ge[k][l] ? DVS_W'(rem_sh[k][l] - {1'b0, side_cur[k].dvs})
                                        : rem_sh[k][l][DVS_W-1:0];
               nq_ff[k][l]  <= {nq_cur[k][l][NUM_W-2:0], ge[k][l]};
            end
         end
         status_ff <= side_ff[NUM_W-1].status;
         plus_ff   <= ((side_ff[NUM_W-1].status == ST_ONE) ||
                       (side_ff[NUM_W-1].status == ST_TWO)) ? vsat[0] : '0;
         minus_ff  <= (side_ff[NUM_W-1].status == ST_TWO) ? vsat[1] : '0;
      end
   end

   assign out_valid  = ovalid_ff;
   assign out_status = status_ff;
   assign out_plus   = plus_ff;
   assign out_minus  = minus_ff;
endmodule
`default_nettype wire

// ----- sv/quadratic_root_solver_core.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// real roots of a*x^2 + b*x + c in signed fixed point
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the response is not stalled,
// set by the bit-per-stage root and divider
// a stalled response holds every stage in place
// reset clears the stage valid bits only
`default_nettype none
module quadratic_root_solver_core (
   input wire logic   clock,
   input wire logic   reset,
   qrs_req_if.sink    req_chan,
   qrs_rsp_if.source  rsp_chan
);
   import qrs_pkg::*;

   logic              en;
   logic              d_valid, s_valid, s_exact;
   side_type          d_side, s_side;
   logic [DISC_W-2:0] d_disc;
   logic [RT_W-1:0]   s_root;

   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   qrs_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_a      (req_chan.coef_quad),
      .in_b      (req_chan.coef_lin),
      .in_c      (req_chan.coef_const),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_disc  (d_disc)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_side   (d_side),
      .in_disc   (d_disc),
      .out_valid (s_valid),
      .out_side  (s_side),
      .out_root  (s_root),
      .out_exact (s_exact)
   );

   qrs_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s_valid),
      .in_side    (s_side),
      .in_root    (s_root),
      .in_exact   (s_exact),
      .out_valid  (rsp_chan.valid),
      .out_status (rsp_chan.root_status),
      .out_plus   (rsp_chan.root_plus),
      .out_minus  (rsp_chan.root_minus)
   );
endmodule
`default_nettype wire

// ----- sv/qrs_checker.sv -----
// ----------------------------------------------------------------------------
// qrs_checker
// port-level checks on the quadratic root solver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadratic_root_solver_core_macros.svh"
module qrs_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [1:0]                       rsp_status,
   input wire logic signed [qrs_pkg::ROOT_W-1:0] rsp_plus,
   input wire logic signed [qrs_pkg::ROOT_W-1:0] rsp_minus
);
   import qrs_pkg::*;

   `QRS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `QRS_ASSERT_IMP(a_ready_tracks, 1'b1, req_ready == (!rsp_valid || rsp_ready))
   `QRS_ASSERT_IMP(a_notq_zero, rsp_valid && (rsp_status == ST_NOTQ), (rsp_plus == '0) && (rsp_minus == '0))
   `QRS_ASSERT_IMP(a_minus_zero, rsp_valid && (rsp_status != ST_TWO), rsp_minus == '0)
endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.root_status),
   .rsp_plus   (rsp_chan.root_plus),
   .rsp_minus  (rsp_chan.root_minus)
);
`default_nettype wire
